/* hdl/olad_pkg.sv */
// Shared types, constants and helpers for the ordered list block.
package olad_pkg;

	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int COUNT_W     = $clog2(CAPACITY + 1);
	localparam int LEN_W       = 5;
	localparam int POS_W       = 4;

	localparam logic [1:0] OP_APPEND  = 2'd0;
	localparam logic [1:0] OP_DELETE  = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;
	localparam logic [1:0] OP_IGNORED = 2'd3;

	localparam logic [1:0] STATUS_DONE     = 2'd0;
	localparam logic [1:0] STATUS_NO_MATCH = 2'd1;
	localparam logic [1:0] STATUS_FULL     = 2'd2;

	typedef logic [VALUE_WIDTH-1:0] elem_t;

	typedef struct packed {
		logic        [1:0]  op;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [LEN_W-1:0] length;
		logic [POS_W-1:0] position;
	} rsp_t;

	typedef struct packed {
		logic append_here;
		logic delete_op;
		logic occupied;
	} cell_ctl_t;

	// The 32-bit input is sign-extended and then kept in VALUE_WIDTH bits.
	function automatic elem_t to_elem(input logic signed [31:0] v);
		logic signed [63:0] wide;
		wide = 64'(v);
		return wide[VALUE_WIDTH-1:0];
	endfunction

endpackage

/* hdl/olad_cell.sv */
// One list slot: holds an entry, compares it with the key and shifts on delete.
module olad_cell import olad_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  elem_t     key,
	input  elem_t     next_value,
	input  logic      hit_in,
	output logic      hit_out,
	output logic      first,
	output elem_t     value_q
);

	logic match;

	assign match   = ctl.occupied && (value_q == key);
	assign hit_out = hit_in || match;
	assign first   = match && !hit_in;

	// On append the slot takes the key; on delete every slot at or after the first match takes its neighbor's entry.
	always_ff @(posedge clk) begin
		if (ctl.append_here) begin
			value_q <= key;
		end else if (ctl.delete_op && hit_out) begin
			value_q <= next_value;
		end
	end

endmodule

/* hdl/ordered_list_append_delete.sv */
// Ordered list with append, delete-first-match and clear, built as a chain of slot cells.
// Throughput: one request per cycle while req_stall is low; all slots compare in parallel
// and shift in one step. The response word of an accepted request is registered.
// A response waiting under stall holds the request side stalled as well.
// Reset clears the entry count and the response valid; slot contents are not cleared.
module ordered_list_append_delete import olad_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_d;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	rsp_t               rsp_d;

	elem_t              key;
	logic               take;
	logic               room;
	logic               found;
	logic [POS_W-1:0]   match_pos;
	cell_ctl_t          ctl   [CAPACITY];
	elem_t              slot  [CAPACITY];
	logic [CAPACITY:0]  hit;
	logic [CAPACITY-1:0] first;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign take      = req_valid && !req_stall;
	assign key       = to_elem(req.value);
	assign room      = count_q < COUNT_W'(CAPACITY);
	assign hit[0]    = 1'b0;
	assign found     = hit[CAPACITY];

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			always_comb begin
				ctl[g].append_here = take && (req.op == OP_APPEND) && room &&
					(count_q == COUNT_W'(g));
				ctl[g].delete_op   = take && (req.op == OP_DELETE);
				ctl[g].occupied    = COUNT_W'(g) < count_q;
			end

			olad_cell u_cell (
				.clk        (clk),
				.ctl        (ctl[g]),
				.key        (key),
				.next_value (slot[(g + 1 < CAPACITY) ? g + 1 : g]),
				.hit_in     (hit[g]),
				.hit_out    (hit[g+1]),
				.first      (first[g]),
				.value_q    (slot[g])
			);
		end
	endgenerate

	always_comb begin
		match_pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first[i]) begin
				match_pos = match_pos | POS_W'(i);
			end
		end
	end

	always_comb begin
		count_d       = count_q;
		rsp_d.status  = STATUS_DONE;
		rsp_d.position = '0;
		case (req.op)
			OP_APPEND: begin
				if (room) begin
					count_d        = count_q + COUNT_W'(1);
					rsp_d.position = POS_W'(count_q);
				end else begin
					rsp_d.status = STATUS_FULL;
				end
			end
			OP_DELETE: begin
				if (found) begin
					count_d        = count_q - COUNT_W'(1);
					rsp_d.position = match_pos;
				end else begin
					rsp_d.status = STATUS_NO_MATCH;
				end
			end
			OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
		rsp_d.length = LEN_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* hdl/olad_checker.sv */
// Port-level checks for the ordered list block, bound to its top level.
module olad_checker import olad_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// Every accepted request word must be followed by a valid response word.
	a_req_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("accepted request gave no response");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp.length) <= CAPACITY)
		else $error("length beyond capacity");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != STATUS_DONE) |-> rsp.position == '0)
		else $error("position not zero on failed operation");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STATUS_FULL) |-> 32'(rsp.length) == CAPACITY)
		else $error("full status with list not full");

endmodule

bind ordered_list_append_delete olad_checker u_olad_checker (.*);
